// ----- design/psbw_pkg.sv -----
package psbw_pkg;

  // default sizes
  localparam int MAX_SEQS_DEF = 64;
  localparam int MAX_COLS_DEF = 256;
  localparam int ALPHABET_DEF = 20;

  // register and field widths
  localparam int SEQ_COUNT_W = 7;
  localparam int COL_COUNT_W = 9;
  localparam int CODE_W      = 5;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int SEQ_INDEX_W = 6;
  localparam int WEIGHT_W    = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_CODE     = 2'd2;

  // register reset values
  localparam logic [SEQ_COUNT_W-1:0] SEQ_COUNT_RST = 7'd1;
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 9'd1;
  localparam logic [CODE_W-1:0]      GAP_CODE_RST  = 5'd21;

  // arithmetic
  localparam int                ACC_W       = 40;
  localparam logic [ACC_W-1:0]  INIT_WEIGHT = 40'd4295;
  localparam int                LENGTH_BIAS = 30;
  localparam int                NUM_W       = 36;
  localparam int                DIV_STEP    = 4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COL_START,
    ST_TALLY,
    ST_TALLY_END,
    ST_COL_CHK,
    ST_W_RD,
    ST_W_MUL1,
    ST_W_MUL2,
    ST_W_DIV,
    ST_W_WB,
    ST_O_RD,
    ST_O_SHOW
  } state_t;

endpackage

// ----- design/psbw_ram.sv -----
module psbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/psbw_div.sv -----
module psbw_div
  import psbw_pkg::*;
#(
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int ITERS  = NUM_W / DIV_STEP;
  localparam int ITER_W = $clog2(ITERS + 1);

  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    rem;
  logic [DEN_W:0]    rem_next;
  logic [NUM_W-1:0]  quo_next;
  logic [ITER_W-1:0] iter;
  logic              busy;

  // several restoring steps per cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_STEP; i++) begin
      rem_next = {rem_next[DEN_W-1:0], quo_next[NUM_W-1]};
      quo_next = {quo_next[NUM_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den_q}) begin
        rem_next    = rem_next - {1'b0, den_q};
        quo_next[0] = 1'b1;
      end
    end
  end

  // rounded reciprocal: (2^32 + den/2) / den
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= '0;
      quo   <= (NUM_W'(1) << 32) + NUM_W'(den >> 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a running division");
`endif

endmodule

// ----- design/position_based_sequence_weights_core.sv -----
// load: residues load at one per cycle while in_ready is high; after the final residue each column
//   is tallied over every sequence, then each amino-acid residue is read, multiplied, divided and
//   accumulated, paced by the single iterative divider and memory ports
// output: each weight item is read from memory, then held until out_ready takes it
// reset: control, counters and config registers return to defaults; alignment contents are
//   undefined until loaded, weights are initialized while each sequence loads
module position_based_sequence_weights_core
  import psbw_pkg::*;
#(
  parameter int MAX_SEQS = MAX_SEQS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CODE_W-1:0]      residue,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SEQ_INDEX_W-1:0] seq_index,
  output logic [WEIGHT_W-1:0]    weight,
  output logic                   last_weight
);

  localparam int SI_W   = $clog2(MAX_SEQS);
  localparam int NS_W   = $clog2(MAX_SEQS + 1);
  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int NC_W   = $clog2(MAX_COLS + 1);
  localparam int NR_W   = NC_W + 1;
  localparam int ADDR_W = $clog2(MAX_SEQS * MAX_COLS);
  localparam int AI_W   = $clog2(ALPHABET);
  localparam int DST_W  = $clog2(ALPHABET + 1);
  localparam int P1_W   = NS_W + DST_W;
  localparam int DEN_W  = P1_W + NR_W;

  state_t state, state_next;

  logic [SEQ_COUNT_W-1:0] seq_count;
  logic [COL_COUNT_W-1:0] column_count;
  logic [CODE_W-1:0]      gap_code;
  logic [NS_W-1:0]        ns;
  logic [NC_W-1:0]        nc;

  logic [ADDR_W-1:0] load_pos;
  logic [CI_W-1:0]   lc;
  logic [SI_W-1:0]   ls;
  logic [NC_W-1:0]   nr;
  logic [SI_W-1:0]   k;
  logic [CI_W-1:0]   c;
  logic [ADDR_W-1:0] base;
  logic              t_valid;
  logic [NS_W-1:0]   tally [ALPHABET];
  logic [DST_W-1:0]  distinct;
  logic [P1_W-1:0]   p1;
  logic [NR_W-1:0]   nrb;

  logic in_acc, lc_last, ls_last, k_last, c_last, nongap, cfg_restart;
  logic [CODE_W-1:0] code;
  logic              amino;
  logic [AI_W-1:0]   idx;

  logic              st_we, st_re;
  logic [ADDR_W-1:0] st_raddr;
  logic              tot_we, tot_re;
  logic [NC_W-1:0]   tot_rd;
  logic              acc_we, acc_re, acc_load_we, acc_wb_we;
  logic [SI_W-1:0]   acc_waddr;
  logic [ACC_W-1:0]  acc_wdata, acc_rd;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [31:0]       k_wide;

  // effective counts
  always_comb begin
    if (seq_count == '0) begin
      ns = NS_W'(1);
    end else if (int'(seq_count) > MAX_SEQS) begin
      ns = NS_W'(MAX_SEQS);
    end else begin
      ns = NS_W'(seq_count);
    end
    if (column_count == '0) begin
      nc = NC_W'(1);
    end else if (int'(column_count) > MAX_COLS) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(column_count);
    end
  end

  assign in_acc  = in_valid && in_ready;
  assign lc_last = (NC_W'(lc) + NC_W'(1)) == nc;
  assign ls_last = (NS_W'(ls) + NS_W'(1)) == ns;
  assign k_last  = (NS_W'(k) + NS_W'(1)) == ns;
  assign c_last  = (NC_W'(c) + NC_W'(1)) == nc;
  assign nongap  = residue != gap_code;
  assign amino   = (code != gap_code) && (int'(code) < ALPHABET);
  assign idx     = code[AI_W-1:0];

  // a write to a known register restarts the load
  assign cfg_restart = cfg_write && (cfg_index == REG_SEQ_COUNT ||
                       cfg_index == REG_COLUMN_COUNT || cfg_index == REG_GAP_CODE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && lc_last && ls_last && !cfg_restart) state_next = ST_COL_START;
      end
      ST_COL_START: state_next = ST_TALLY;
      ST_TALLY: begin
        if (k_last) state_next = ST_TALLY_END;
      end
      ST_TALLY_END: state_next = ST_COL_CHK;
      ST_COL_CHK: begin
        if (distinct != '0) state_next = ST_W_RD;
        else if (c_last) state_next = ST_O_RD;
        else state_next = ST_COL_START;
      end
      ST_W_RD: state_next = ST_W_MUL1;
      ST_W_MUL1: begin
        if (amino) state_next = ST_W_MUL2;
        else if (!k_last) state_next = ST_W_RD;
        else if (c_last) state_next = ST_O_RD;
        else state_next = ST_COL_START;
      end
      ST_W_MUL2: state_next = ST_W_DIV;
      ST_W_DIV: begin
        if (div_done) state_next = ST_W_WB;
      end
      ST_W_WB: begin
        if (!k_last) state_next = ST_W_RD;
        else if (c_last) state_next = ST_O_RD;
        else state_next = ST_COL_START;
      end
      ST_O_RD: state_next = ST_O_SHOW;
      ST_O_SHOW: begin
        if (out_ready) state_next = k_last ? ST_LOAD : ST_O_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // memory controls and handshakes
  always_comb begin
    in_ready    = state == ST_LOAD;
    out_valid   = state == ST_O_SHOW;
    st_we       = in_acc;
    st_re       = (state == ST_TALLY) || (state == ST_W_RD);
    st_raddr    = base + ADDR_W'(c);
    tot_we      = in_acc && lc_last;
    tot_re      = state == ST_W_RD;
    acc_load_we = in_acc && lc_last;
    acc_wb_we   = state == ST_W_WB;
    acc_we      = acc_load_we || acc_wb_we;
    acc_re      = (state == ST_W_RD) || (state == ST_O_RD);
    acc_waddr   = acc_wb_we ? k : ls;
    acc_wdata   = acc_wb_we ? acc_rd + ACC_W'(div_quo) : INIT_WEIGHT;
    div_start   = state == ST_W_MUL2;
  end

  // config registers and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      seq_count    <= SEQ_COUNT_RST;
      column_count <= COL_COUNT_RST;
      gap_code     <= GAP_CODE_RST;
      load_pos     <= '0;
      lc           <= '0;
      ls           <= '0;
      nr           <= '0;
      k            <= '0;
      c            <= '0;
      base         <= '0;
      t_valid      <= 1'b0;
      distinct     <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SEQ_COUNT:    seq_count    <= cfg_data[SEQ_COUNT_W-1:0];
          REG_COLUMN_COUNT: column_count <= cfg_data[COL_COUNT_W-1:0];
          REG_GAP_CODE:     gap_code     <= cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (cfg_restart) begin
        load_pos <= '0;
        lc       <= '0;
        ls       <= '0;
        nr       <= '0;
      end else if (in_acc) begin
        // load one residue, close a sequence at its last column
        if (lc_last && ls_last) begin
          lc       <= '0;
          nr       <= '0;
          ls       <= '0;
          load_pos <= '0;
          c        <= '0;
        end else if (lc_last) begin
          load_pos <= load_pos + 1'b1;
          lc       <= '0;
          nr       <= '0;
          ls       <= ls + 1'b1;
        end else begin
          load_pos <= load_pos + 1'b1;
          lc       <= lc + 1'b1;
          nr       <= nr + NC_W'(nongap);
        end
      end

      // tally results of the previous read
      if (t_valid && amino) begin
        if (tally[idx] == '0) distinct <= distinct + 1'b1;
      end

      unique case (state) inside
        ST_COL_START: begin
          k        <= '0;
          base     <= '0;
          distinct <= '0;
          t_valid  <= 1'b0;
        end
        ST_TALLY: begin
          t_valid <= 1'b1;
          k       <= k + 1'b1;
          base    <= base + ADDR_W'(nc);
        end
        ST_TALLY_END: t_valid <= 1'b0;
        ST_COL_CHK: begin
          k    <= '0;
          base <= '0;
          if (distinct == '0) c <= c + 1'b1;
        end
        ST_W_MUL1, ST_W_WB: begin
          if (state == ST_W_WB || !amino) begin
            if (k_last) begin
              k    <= '0;
              base <= '0;
              c    <= c + 1'b1;
            end else begin
              k    <= k + 1'b1;
              base <= base + ADDR_W'(nc);
            end
          end
        end
        ST_O_SHOW: begin
          if (out_ready) k <= k_last ? '0 : k + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // tally counters, cleared at each column start
  always_ff @(posedge clk) begin
    if (rst || state == ST_COL_START) begin
      for (int a = 0; a < ALPHABET; a++) tally[a] <= '0;
    end else if (t_valid && amino) begin
      tally[idx] <= tally[idx] + 1'b1;
    end
  end

  // denominator factors
  always_ff @(posedge clk) begin
    if (state == ST_W_MUL1) begin
      p1  <= P1_W'(tally[idx]) * P1_W'(distinct);
      nrb <= NR_W'(tot_rd) + NR_W'(LENGTH_BIAS);
    end
  end

  psbw_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SEQS * MAX_COLS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (load_pos),
    .wdata (residue),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (code)
  );

  psbw_ram #(.WIDTH(NC_W), .DEPTH(MAX_SEQS)) u_totals (
    .clk   (clk),
    .we    (tot_we),
    .waddr (ls),
    .wdata (nr + NC_W'(nongap)),
    .re    (tot_re),
    .raddr (k),
    .rdata (tot_rd)
  );

  psbw_ram #(.WIDTH(ACC_W), .DEPTH(MAX_SEQS)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (k),
    .rdata (acc_rd)
  );

  psbw_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (DEN_W'(p1) * DEN_W'(nrb)),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result item
  assign k_wide      = 32'(k);
  assign seq_index   = k_wide[SEQ_INDEX_W-1:0];
  assign weight      = (acc_rd[ACC_W-1:WEIGHT_W] != '0) ? '1 : acc_rd[WEIGHT_W-1:0];
  assign last_weight = k_last;

`ifndef SYNTHESIS
  a_no_dual_acc_write: assert property (@(posedge clk) disable iff (rst)
    !(acc_load_we && acc_wb_we)) else $error("two writes to weight memory");
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_W_DIV) else $error("divide finished outside its state");
  a_load_to_compute: assert property (@(posedge clk) disable iff (rst)
    (in_acc && lc_last && ls_last && !cfg_write) |=> state == ST_COL_START)
    else $error("final residue did not start the column pass");
  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    int'(distinct) <= ALPHABET) else $error("distinct count too large");
`endif

endmodule
